// ----- rtl/smmof_pkg.sv -----
package smmof_pkg;

  // default parameter values
  localparam int MAX_RADIUS_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 32;

  // fixed field widths
  localparam int VALUE_W    = 32;
  localparam int TAG_W      = 24;
  localparam int GAIN_W     = 16;
  localparam int RADIUS_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd768;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 5'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sample_value;
    logic [TAG_W-1:0]          sample_tag;
    logic                      in_last;
  } in_item_t;

  typedef struct packed {
    logic [TAG_W-1:0] result_tag;
    logic             is_outlier;
    logic             out_last;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic setup;
    logic load;
    logic sel;
    logic med;
    logic dev;
    logic mad;
    logic mul;
    logic emit;
    logic clear_fill;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic emit_need;
    logic load_last;
    logic sel_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/smmof_ctrl.sv -----
module smmof_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  smmof_pkg::dp_stat_t st,
  output smmof_pkg::ctl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_LOAD, S_LWAIT, S_SEL1, S_MED, S_DEV,
    S_SEL2, S_MAD, S_MUL, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.emit_need) begin
          cmd.setup = 1'b1;
          state_nxt = S_LOAD;
        end else begin
          cmd.clear_fill = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        if (st.load_last) state_nxt = S_LWAIT;
      end
      S_LWAIT: state_nxt = S_SEL1;
      S_SEL1: begin
        cmd.sel = 1'b1;
        if (st.sel_last) state_nxt = S_MED;
      end
      S_MED: begin
        cmd.med   = 1'b1;
        state_nxt = S_DEV;
      end
      S_DEV: begin
        cmd.dev   = 1'b1;
        state_nxt = S_SEL2;
      end
      S_SEL2: begin
        cmd.sel = 1'b1;
        if (st.sel_last) state_nxt = S_MAD;
      end
      S_MAD: begin
        cmd.mad   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ----- rtl/smmof_dp.sv -----
module smmof_dp #(
  parameter int MAX_RADIUS  = smmof_pkg::MAX_RADIUS_DEF,
  parameter int SAMPLE_BITS = smmof_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  smmof_pkg::in_item_t                 in_data,
  input  logic                                cfg_valid,
  input  logic [smmof_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [smmof_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                out_stall,
  output logic                                out_valid,
  output smmof_pkg::out_item_t                out_data,
  input  smmof_pkg::ctl_cmd_t                 cmd,
  output smmof_pkg::dp_stat_t                 st
);

  localparam int D  = 2 * MAX_RADIUS + 1;
  localparam int AW = $clog2(D);
  localparam int CW = $clog2(D + 1);
  localparam int SB = SAMPLE_BITS;
  localparam int LW = SB + 2;
  localparam int TW = smmof_pkg::TAG_W;
  localparam int MW = SB + TW;
  localparam int PW = SB + 2 + smmof_pkg::GAIN_W;

  // configuration registers
  logic [smmof_pkg::GAIN_W-1:0]   gain_r;
  logic [smmof_pkg::RADIUS_W-1:0] radius_r;

  // sequence state
  logic [AW-1:0] head_r;
  logic [CW-1:0] fill_r, pend_r;
  logic          last_r;

  // verdict window
  logic [CW-1:0] d_r, lo_r, n_r, idx_r;
  logic [MW-1:0] mem [D];
  logic [MW-1:0] rd_q_r;
  logic          rd_v_r;
  logic [CW-1:0] rd_idx_r;

  // lanes for rank selection
  logic signed [LW-1:0] lane_r [D];
  logic [D-1:0]         lane_v_r;
  logic signed [LW-1:0] sel_hi_r, sel_lo_r;

  // verdict arithmetic
  logic signed [SB-1:0] cv_r;
  logic [TW-1:0]        ctag_r;
  logic signed [SB:0]   med2_r;
  logic [SB:0]          devc_r;
  logic [SB+1:0]        mad4_r;
  logic [PW-1:0]        prod_r;

  logic                 out_valid_r;
  smmof_pkg::out_item_t out_data_r;

  // doubled deviation |2x - m2|
  function automatic logic [SB:0] abs_dev(input logic signed [LW-1:0] x,
                                          input logic signed [SB:0] m2);
    logic signed [SB+2:0] t;
    t = ((SB+3)'(x) <<< 1) - (SB+3)'(m2);
    if (t < 0) t = -t;
    return t[SB:0];
  endfunction

  // active radius, clamped to 1..MAX_RADIUS
  logic [CW-1:0] ar;
  always_comb begin
    if (radius_r == '0) ar = CW'(1);
    else if (int'(radius_r) > MAX_RADIUS) ar = CW'(MAX_RADIUS);
    else ar = CW'(radius_r);
  end

  // window bounds of the oldest pending sample
  logic [CW-1:0] d_c, lo_c, hi_a, hi_c, n_c;
  always_comb begin
    d_c  = pend_r - CW'(1);
    lo_c = (d_c > ar) ? d_c - ar : '0;
    hi_a = d_c + ar;
    hi_c = (hi_a > fill_r - CW'(1)) ? fill_r - CW'(1) : hi_a;
    n_c  = hi_c - lo_c + CW'(1);
  end

  // ring slot of an offset back from the newest sample
  logic [CW-1:0] off;
  logic [AW+1:0] slot_t;
  logic [AW-1:0] slot;
  always_comb begin
    off    = lo_r + idx_r;
    slot_t = (AW+2)'(head_r) + (AW+2)'(D - 1) - (AW+2)'(off);
    slot   = (slot_t >= (AW+2)'(D)) ? AW'(slot_t - (AW+2)'(D)) : AW'(slot_t);
  end

  // input value, low sample bits taken as signed
  logic [63:0]          raw64;
  logic signed [SB-1:0] sval;
  always_comb begin
    raw64 = {32'b0, in_data.sample_value};
    sval  = signed'(raw64[SB-1:0]);
  end

  // rank counts of the candidate in lane 0
  logic [D-1:0]  lt_vec, le_vec;
  logic [CW-1:0] lt_cnt, le_cnt, mid, midm1;
  logic          hit_hi, hit_lo;
  always_comb begin
    for (int i = 0; i < D; i++) begin
      lt_vec[i] = lane_v_r[i] && (lane_r[i] < lane_r[0]);
      le_vec[i] = lane_v_r[i] && (lane_r[i] <= lane_r[0]);
    end
    lt_cnt = CW'($countones(lt_vec));
    le_cnt = CW'($countones(le_vec));
    mid    = n_r >> 1;
    midm1  = mid - CW'(1);
    hit_hi = lane_v_r[0] && (lt_cnt <= mid) && (mid < le_cnt);
    hit_lo = lane_v_r[0] && (lt_cnt <= midm1) && (midm1 < le_cnt);
  end

  // threshold test: dev2*512 > gain*mad4, with gain and mad4 both nonzero
  logic flag;
  assign flag = (gain_r != '0) && (mad4_r != '0) && (PW'({devc_r, 9'b0}) > prod_r);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= smmof_pkg::GAIN_RESET;
      radius_r <= smmof_pkg::RADIUS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        smmof_pkg::CFG_GAIN:   gain_r   <= cfg_data;
        smmof_pkg::CFG_RADIUS: radius_r <= cfg_data[smmof_pkg::RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // sequence control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
      pend_r <= '0;
      last_r <= 1'b0;
      idx_r  <= '0;
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.load;
      if (cmd.accept) begin
        head_r <= (head_r == AW'(D - 1)) ? '0 : head_r + AW'(1);
        if (fill_r != CW'(D)) fill_r <= fill_r + CW'(1);
        pend_r <= pend_r + CW'(1);
        last_r <= in_data.in_last;
      end
      if (cmd.clear_fill && last_r) fill_r <= '0;
      if (cmd.emit) pend_r <= pend_r - CW'(1);
      if (cmd.setup) idx_r <= '0;
      else if (cmd.load) idx_r <= (idx_r == n_r - CW'(1)) ? '0 : idx_r + CW'(1);
      else if (cmd.sel) idx_r <= (idx_r == CW'(D - 1)) ? '0 : idx_r + CW'(1);
    end
  end

  // sample memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.accept) mem[head_r] <= {in_data.sample_tag, sval};
    if (cmd.load) begin
      rd_q_r   <= mem[slot];
      rd_idx_r <= idx_r;
    end
  end

  // lanes: load, rotate, deviations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_v_r <= '0;
    end else if (cmd.setup) begin
      lane_v_r <= '0;
    end else if (rd_v_r) begin
      lane_r[rd_idx_r[AW-1:0]]   <= LW'(signed'(rd_q_r[SB-1:0]));
      lane_v_r[rd_idx_r[AW-1:0]] <= 1'b1;
    end else if (cmd.sel) begin
      for (int i = 0; i < D; i++) lane_r[i] <= lane_r[(i + 1) % D];
      lane_v_r <= {lane_v_r[0], lane_v_r[D-1:1]};
    end else if (cmd.dev) begin
      for (int i = 0; i < D; i++) lane_r[i] <= LW'(abs_dev(lane_r[i], med2_r));
    end
  end

  // verdict payload registers
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      d_r  <= d_c;
      lo_r <= lo_c;
      n_r  <= n_c;
    end
    if (rd_v_r && (rd_idx_r == d_r - lo_r)) begin
      cv_r   <= signed'(rd_q_r[SB-1:0]);
      ctag_r <= rd_q_r[MW-1:SB];
    end
    if (cmd.sel && hit_hi) sel_hi_r <= lane_r[0];
    if (cmd.sel && hit_lo) sel_lo_r <= lane_r[0];
    if (cmd.med) begin
      med2_r <= n_r[0] ? ((SB+1)'(sel_hi_r) <<< 1)
                       : (SB+1)'(sel_hi_r) + (SB+1)'(sel_lo_r);
    end
    if (cmd.dev) devc_r <= abs_dev(LW'(cv_r), med2_r);
    if (cmd.mad) begin
      mad4_r <= n_r[0] ? (unsigned'(sel_hi_r) << 1)
                       : unsigned'(sel_hi_r) + unsigned'(sel_lo_r);
    end
    if (cmd.mul) prod_r <= PW'(gain_r) * PW'(mad4_r);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.result_tag <= ctag_r;
      out_data_r.is_outlier <= flag;
      out_data_r.out_last   <= last_r && (d_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // status
  assign st.emit_need = last_r ? (pend_r != '0) : (pend_r > ar);
  assign st.load_last = (idx_r == n_r - CW'(1));
  assign st.sel_last  = (idx_r == CW'(D - 1));
  assign st.out_free  = !out_valid_r || !out_stall;

endmodule

// ----- rtl/sliding_median_mad_outlier_flag.sv -----
// channel  | direction | handshake          | payload
// in_      | input     | in_valid/in_stall  | in_data (in_item_t)
// out_     | output    | out_valid/out_stall| out_data (out_item_t)
// cfg_     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// an input transaction is accepted and then checked for due verdicts; each
// verdict may wait for the output register: the n entries of its window
// (n being the window count) are read one entry a cycle from the
// sample memory, then two rank selections each rotate all 2*MAX_RADIUS+1
// lanes past one comparator row.
// reset is synchronous; no clearing pass, the sample memory is never read
// before it is written in the current sequence.
// a verdict waits in the output register while the next sample is taken.
module sliding_median_mad_outlier_flag #(
  parameter int MAX_RADIUS  = smmof_pkg::MAX_RADIUS_DEF,
  parameter int SAMPLE_BITS = smmof_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  smmof_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output smmof_pkg::out_item_t             out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [smmof_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [smmof_pkg::CFG_DATA_W-1:0] cfg_data
);

  smmof_pkg::ctl_cmd_t cmd;
  smmof_pkg::dp_stat_t st;

  assign cfg_ready = 1'b1;

  // sequencer
  smmof_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // window store and arithmetic
  smmof_dp #(
    .MAX_RADIUS  (MAX_RADIUS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

  // an accepted transaction is followed by a busy input (in_stall high)
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken without a busy cycle");

  // a new verdict appears only while a sample is being worked on
  a_verdict_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_stall)
    else $error("verdict appeared while idle");

  // a verdict is only loaded while the output register is free
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.out_free)
    else $error("verdict overwrote a waiting result");

endmodule
